### rtl/kwm_pkg.sv
// kwm_pkg: shared types and constants of the k-way sorted run merge
// field widths, status and action codes, run table command struct
// no dependencies
package kwm_pkg;

  localparam int FIELD_W    = 64;
  localparam int RUN_FLD_W  = 3;
  localparam int CFG_W      = 4;
  localparam int STATUS_W   = 3;
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 136;
  localparam int PAD_W      = 5;

  localparam logic [CFG_W-1:0] NUM_RUNS_RESET = 4'd8;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_PUSHED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADRUN = 3'd2;
  localparam logic [STATUS_W-1:0] ST_POPPED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd4;

  typedef struct packed {
    logic push;
    logic pop;
  } kwm_tbl_cmd_t;

endpackage

### rtl/kwm_ram.sv
// kwm_ram: generic single-port-write, single-port-read synchronous ram
// registered read data
// no dependencies
module kwm_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/kwm_run_table.sv
// kwm_run_table: head pointer, tail pointer and fill count of every run
// one selected run is read and updated per cycle
// depends on kwm_pkg
module kwm_run_table
  import kwm_pkg::*;
#(
  parameter int MAX_RUNS  = 8,
  parameter int RUN_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [$clog2(MAX_RUNS)-1:0]      sel,
  input  kwm_tbl_cmd_t                     cmd,
  output logic [$clog2(RUN_DEPTH)-1:0]     head,
  output logic [$clog2(RUN_DEPTH)-1:0]     tail,
  output logic [$clog2(RUN_DEPTH+1)-1:0]   fill
);

  localparam int PW = $clog2(RUN_DEPTH);
  localparam int FW = $clog2(RUN_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(RUN_DEPTH - 1);

  logic [PW-1:0] run_head [MAX_RUNS];
  logic [PW-1:0] run_tail [MAX_RUNS];
  logic [FW-1:0] run_fill [MAX_RUNS];

  assign head = run_head[sel];
  assign tail = run_tail[sel];
  assign fill = run_fill[sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_RUNS; i++) begin
        run_head[i] <= '0;
        run_tail[i] <= '0;
        run_fill[i] <= '0;
      end
    end else begin
      if (cmd.push) begin
        run_tail[sel] <= (tail == PTR_LAST) ? '0 : tail + PW'(1);
        run_fill[sel] <= fill + FW'(1);
      end
      if (cmd.pop) begin
        run_head[sel] <= (head == PTR_LAST) ? '0 : head + PW'(1);
        run_fill[sel] <= fill - FW'(1);
      end
    end
  end

endmodule

### rtl/k_way_sorted_run_merge.sv
// k_way_sorted_run_merge: top level of the k-way merge of sorted runs
// depends on kwm_pkg, kwm_ram, kwm_run_table
//
// usage:
//   slave stream carries commands: tuser is the action (push or pop), tdata
//   the run index, key and payload of a pushed record. every command gives
//   exactly one transaction on the master stream: tuser is the status, tdata
//   the popped key, payload and source run (zero when nothing was popped).
//   cfg channel writes num_runs; it is always ready and takes effect at once.
// sequencing:
//   a push result is registered from the push state. a pop scans the head
//   of each effective run through the record memory read port, one run per
//   cycle, then a drain state ends the compare of the last read and a final
//   state registers the result and updates the winning run.
//   one command is in flight at a time; tready is high while idle.
// reset:
//   synchronous rst empties every run and sets num_runs to 8; record memory
//   needs no clearing since only written entries are ever read.
// stall:
//   the result sits in an output register; if it is not taken, the next
//   command is still accepted and waits at its final step until the
//   register frees up.
module k_way_sorted_run_merge
  import kwm_pkg::*;
#(
  parameter int MAX_RUNS  = 8,
  parameter int RUN_DEPTH = 64,
  parameter int KEY_BITS  = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // run_index, record_key, record_payload
  input  logic                  s_tuser,   // action
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // out_key, out_payload, source_run
  output logic [STATUS_W-1:0]   m_tuser    // status
);

  localparam int RW = $clog2(MAX_RUNS);
  localparam int PW = $clog2(RUN_DEPTH);
  localparam int FW = $clog2(RUN_DEPTH + 1);
  localparam int AW = $clog2(MAX_RUNS * RUN_DEPTH);
  localparam int CW = ($clog2(MAX_RUNS + 1) > CFG_W) ? $clog2(MAX_RUNS + 1) : CFG_W;
  localparam int MW = KEY_BITS + FIELD_W;
  localparam logic [AW-1:0] RD_A = AW'(RUN_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PUSH  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_POPF  = 3'd4;

  logic [2:0]          state;
  logic [CFG_W-1:0]    num_runs;
  logic [RUN_FLD_W-1:0] run_q;
  logic [KEY_BITS-1:0] key_q;
  logic [FIELD_W-1:0]  pay_q;
  logic [RW-1:0]       idx;
  logic                pend;
  logic [RW-1:0]       pend_run;
  logic                found;
  logic [RW-1:0]       best_run;
  logic [KEY_BITS-1:0] best_key;
  logic [FIELD_W-1:0]  best_pay;

  logic [CW-1:0]       n_eff;
  logic [CW-1:0]       run_ext;
  logic                run_bad;
  logic                run_full;
  logic                out_free;
  logic                scan_last;
  logic [RW-1:0]       tbl_sel;
  kwm_tbl_cmd_t        tbl_cmd;
  logic [PW-1:0]       tbl_head;
  logic [PW-1:0]       tbl_tail;
  logic [FW-1:0]       tbl_fill;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [MW-1:0]       ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [MW-1:0]       ram_rdata;
  logic [KEY_BITS-1:0] rd_key;
  logic [FIELD_W-1:0]  rd_pay;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    logic [CW-1:0] nr;
    nr = CW'(num_runs);
    if (nr < CW'(2)) begin
      n_eff = CW'(2);
    end else if (nr > CW'(MAX_RUNS)) begin
      n_eff = CW'(MAX_RUNS);
    end else begin
      n_eff = nr;
    end
  end

  assign run_ext   = CW'(run_q);
  assign run_bad   = run_ext >= n_eff;
  assign run_full  = tbl_fill == FW'(RUN_DEPTH);
  assign scan_last = (CW'(idx) + CW'(1)) == n_eff;

  always_comb begin
    case (state)
      S_PUSH:  tbl_sel = run_ext[RW-1:0];
      S_SCAN:  tbl_sel = idx;
      default: tbl_sel = best_run;
    endcase
  end

  assign ram_we    = (state == S_PUSH) && out_free && !run_bad && !run_full;
  assign ram_waddr = AW'(tbl_sel) * RD_A + AW'(tbl_tail);
  assign ram_wdata = {pay_q, key_q};
  assign ram_re    = (state == S_SCAN) && (tbl_fill != '0);
  assign ram_raddr = AW'(tbl_sel) * RD_A + AW'(tbl_head);
  assign rd_key    = ram_rdata[KEY_BITS-1:0];
  assign rd_pay    = ram_rdata[KEY_BITS +: FIELD_W];

  assign tbl_cmd.push = ram_we;
  assign tbl_cmd.pop  = (state == S_POPF) && out_free && found;

  kwm_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_RUNS * RUN_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kwm_run_table #(
    .MAX_RUNS  (MAX_RUNS),
    .RUN_DEPTH (RUN_DEPTH)
  ) u_table (
    .clk  (clk),
    .rst  (rst),
    .sel  (tbl_sel),
    .cmd  (tbl_cmd),
    .head (tbl_head),
    .tail (tbl_tail),
    .fill (tbl_fill)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      num_runs <= NUM_RUNS_RESET;
    end else if (cfg_valid) begin
      num_runs <= cfg_data;
    end
  end

  // head compare, ties go to the later (higher) run
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      found <= 1'b0;
    end else if (pend && (!found || rd_key <= best_key)) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pend && (!found || rd_key <= best_key)) begin
      best_run <= pend_run;
      best_key <= rd_key;
      best_pay <= rd_pay;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      run_q <= s_tdata[RUN_FLD_W-1:0];
      key_q <= s_tdata[RUN_FLD_W +: KEY_BITS];
      pay_q <= s_tdata[RUN_FLD_W + FIELD_W +: FIELD_W];
    end
    pend_run <= idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      idx      <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == S_PUSH || state == S_POPF) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      pend <= ram_re;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            idx   <= '0;
            state <= (s_tuser == ACT_POP) ? S_SCAN : S_PUSH;
          end
        end
        S_PUSH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (scan_last) begin
            state <= S_DRAIN;
          end else begin
            idx <= idx + RW'(1);
          end
        end
        S_DRAIN: begin
          state <= S_POPF;
        end
        S_POPF: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PUSH && out_free) begin
      m_tdata <= '0;
      if (run_bad) begin
        m_tuser <= ST_BADRUN;
      end else if (run_full) begin
        m_tuser <= ST_FULL;
      end else begin
        m_tuser <= ST_PUSHED;
      end
    end else if (state == S_POPF && out_free) begin
      if (found) begin
        m_tuser <= ST_POPPED;
        m_tdata <= {{PAD_W{1'b0}}, RUN_FLD_W'(best_run), best_pay, FIELD_W'(best_key)};
      end else begin
        m_tuser <= ST_EMPTY;
        m_tdata <= '0;
      end
    end
  end

endmodule

### rtl/kwm_checker.sv
// kwm_checker: port-level checks of k_way_sorted_run_merge, bound to the top
// depends on kwm_pkg
module kwm_checker
  import kwm_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [STATUS_W-1:0]   m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= ST_EMPTY)
    else $error("status code out of range");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_POPPED |-> m_tdata == '0)
    else $error("nonzero data on a non-pop result");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second command accepted while one is in flight");

endmodule

bind k_way_sorted_run_merge kwm_checker u_kwm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
